// ----- design/cbor_item_stream_decoder_top_assert.svh -----
// ----------------------------------------------------------------------------
// CBOR item stream decoder assertion macros
// Shared assertion forms for the decoder RTL; compiled out with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef CBOR_ITEM_STREAM_DECODER_TOP_ASSERT_SVH
`define CBOR_ITEM_STREAM_DECODER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
// Check on every rising edge outside reset.
`define CISD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check on every rising edge, reset included.
`define CISD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CISD_ASSERT(lbl, clk, rst_n, prop, msg)
`define CISD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ----- design/cisd_pkg.sv -----
// ----------------------------------------------------------------------------
// CBOR item stream decoder package
// Request and result types, CBOR head constants and decoder codes.
// ----------------------------------------------------------------------------
package cisd_pkg;

    localparam int VALUE_W   = 64;
    localparam int LIMIT_W   = 17;
    localparam int PAYLOAD_W = 16;
    localparam int ARG_CNT_W = 4;

    localparam logic [7:0] MAJOR_MASK     = 8'hE0;
    localparam logic [7:0] INFO_MASK      = 8'h1F;
    localparam logic [4:0] INFO_FIRST_EXT = 5'd24;
    localparam logic [4:0] INFO_ARG_1B    = 5'd24;
    localparam logic [4:0] INFO_ARG_2B    = 5'd25;
    localparam logic [4:0] INFO_ARG_4B    = 5'd26;
    localparam logic [4:0] INFO_ARG_8B    = 5'd27;

    // Major type codes as they sit under MAJOR_MASK.
    localparam logic [7:0] MAJ_UNSIGNED = 8'h00;
    localparam logic [7:0] MAJ_BYTES    = 8'h40;
    localparam logic [7:0] MAJ_TEXT     = 8'h60;

    localparam logic [1:0] KIND_UINT  = 2'd0;
    localparam logic [1:0] KIND_BYTES = 2'd1;
    localparam logic [1:0] KIND_TEXT  = 2'd2;

    localparam logic [1:0] ST_BUSY   = 2'd0;
    localparam logic [1:0] ST_DONE   = 2'd1;
    localparam logic [1:0] ST_REJECT = 2'd2;

    localparam logic [1:0] CAUSE_NONE     = 2'd0;
    localparam logic [1:0] CAUSE_MAJOR    = 2'd1;
    localparam logic [1:0] CAUSE_ARG_SIZE = 2'd2;
    localparam logic [1:0] CAUSE_LENGTH   = 2'd3;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'b001,
        PH_ARG     = 3'b010,
        PH_PAYLOAD = 3'b100
    } t_phase;

    typedef struct packed {
        logic [7:0]         in_byte;
        logic [1:0]         opcode;
        logic [LIMIT_W-1:0] length_limit;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         status;
        logic [1:0]         error_cause;
        logic [VALUE_W-1:0] value;
        logic               payload_valid;
        logic [7:0]         payload_byte;
        logic               last;
    } t_out_item;

    // Handshake between the decoder core and the result queue.
    typedef struct packed {
        logic push;
    } t_q_ctrl;

endpackage

// ----- design/cbor_item_stream_decoder_top.sv -----
// ----------------------------------------------------------------------------
// CBOR item stream decoder, top level
// Byte-wide CBOR head decoder with streamed string payload.
// ----------------------------------------------------------------------------
// Feed the CBOR stream one byte per request. On the first byte of an item the
// opcode (0 unsigned integer, 1 byte string of exact length, 2 text string of
// length below length_limit) and length_limit are sampled; on later bytes they
// are ignored. Every accepted byte yields exactly one result request, queued
// as it is taken: while the head is in flight status is 0 and value
// carries the argument bytes gathered so far; payload bytes of a string come
// out with payload_valid set; the final byte, or any error, carries last and
// status 1 (done) or 2 (rejected, with error_cause). After either the decoder
// waits for a new initial byte. Throughput is one byte per cycle: the whole
// decode of a byte is one pass of logic from the state registers into a
// two-entry result queue, and o_in_stall rises only when that queue holds two
// results that the output side has not yet taken.
// ----------------------------------------------------------------------------
module cbor_item_stream_decoder_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  cisd_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output cisd_pkg::t_out_item o_out_item
);
    import cisd_pkg::*;

    t_q_ctrl   q_ctrl;
    t_out_item step_result;
    logic      q_full;

    // Take a byte whenever the result queue has room.
    assign q_ctrl.push = i_in_valid && !q_full;
    assign o_in_stall  = q_full;

    // Decode state plus the per-byte result logic.
    cisd_step u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (q_ctrl.push),
        .i_item   (i_in_item),
        .o_result (step_result)
    );

    // Hold results until the output side takes them.
    cisd_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (q_ctrl),
        .i_push_item (step_result),
        .o_full      (q_full),
        .o_valid     (o_out_valid),
        .i_stall     (i_out_stall),
        .o_item      (o_out_item)
    );

endmodule

// ----- design/cisd_step.sv -----
// ----------------------------------------------------------------------------
// CBOR item stream decoder core
// Holds the decode state and turns one stream byte into one result.
// ----------------------------------------------------------------------------
`include "cbor_item_stream_decoder_top_assert.svh"

module cisd_step (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  cisd_pkg::t_in_item  i_item,
    output cisd_pkg::t_out_item o_result
);
    import cisd_pkg::*;

    t_phase                r_phase,        n_phase;
    logic [1:0]            r_kind,         n_kind;
    logic [ARG_CNT_W-1:0]  r_arg_left,     n_arg_left;
    logic [VALUE_W-1:0]    r_acc,          n_acc;
    logic [PAYLOAD_W-1:0]  r_payload_left, n_payload_left;
    logic [LIMIT_W-1:0]    r_limit,        n_limit;

    logic [7:0]            type_bits;
    logic [4:0]            info;
    logic                  type_ok;
    logic                  head;
    logic                  reject;
    logic [1:0]            rej_cause;
    logic [VALUE_W-1:0]    limit_ext;
    t_out_item             res;

    assign type_bits = i_item.in_byte & MAJOR_MASK;
    assign info      = 5'(i_item.in_byte & INFO_MASK);

    always_comb begin
        n_phase        = r_phase;
        n_kind         = r_kind;
        n_arg_left     = r_arg_left;
        n_acc          = r_acc;
        n_payload_left = r_payload_left;
        n_limit        = r_limit;
        res            = '0;
        head           = 1'b0;
        reject         = 1'b0;
        rej_cause      = CAUSE_NONE;
        type_ok        = 1'b0;

        case (r_phase)
            PH_ARG: begin
                n_acc      = {r_acc[VALUE_W-9:0], i_item.in_byte};
                n_arg_left = r_arg_left - ARG_CNT_W'(1);
                if (n_arg_left == '0) begin
                    head = 1'b1;
                end else begin
                    res.value = n_acc;
                end
            end
            PH_PAYLOAD: begin
                res.payload_valid = 1'b1;
                res.payload_byte  = i_item.in_byte;
                res.value         = r_acc;
                n_payload_left    = r_payload_left - PAYLOAD_W'(1);
                if (n_payload_left == '0) begin
                    res.status = ST_DONE;
                    res.last   = 1'b1;
                    n_phase    = PH_IDLE;
                    n_arg_left = '0;
                end
            end
            default: begin
                // Initial byte of an item: latch what is expected of it.
                n_kind  = i_item.opcode;
                n_limit = i_item.length_limit;
                n_acc   = '0;
                n_phase = PH_IDLE;
                case (i_item.opcode)
                    KIND_UINT:  type_ok = (type_bits == MAJ_UNSIGNED);
                    KIND_BYTES: type_ok = (type_bits == MAJ_BYTES);
                    KIND_TEXT:  type_ok = (type_bits == MAJ_TEXT);
                    default:    type_ok = 1'b0;
                endcase
                if (!type_ok) begin
                    reject    = 1'b1;
                    rej_cause = CAUSE_MAJOR;
                end else if (info < INFO_FIRST_EXT) begin
                    n_acc = VALUE_W'(info);
                    head  = 1'b1;
                end else begin
                    case (info)
                        INFO_ARG_1B: begin
                            n_arg_left = ARG_CNT_W'(1);
                            n_phase    = PH_ARG;
                        end
                        INFO_ARG_2B: begin
                            n_arg_left = ARG_CNT_W'(2);
                            n_phase    = PH_ARG;
                        end
                        INFO_ARG_4B, INFO_ARG_8B: begin
                            if (i_item.opcode == KIND_UINT) begin
                                n_arg_left = (info == INFO_ARG_4B) ?
                                             ARG_CNT_W'(4) : ARG_CNT_W'(8);
                                n_phase    = PH_ARG;
                            end else begin
                                reject    = 1'b1;
                                rej_cause = CAUSE_ARG_SIZE;
                            end
                        end
                        default: begin
                            reject    = 1'b1;
                            rej_cause = CAUSE_ARG_SIZE;
                        end
                    endcase
                end
            end
        endcase

        // Head complete: finish an integer, or check a string length and finish an empty string or start its payload.
        limit_ext = VALUE_W'(n_limit);
        if (head) begin
            if (n_kind == KIND_UINT) begin
                res.status = ST_DONE;
                res.value  = n_acc;
                res.last   = 1'b1;
                n_phase    = PH_IDLE;
                n_arg_left = '0;
                n_payload_left = '0;
            end else if ((n_kind == KIND_BYTES) ? (n_acc != limit_ext)
                                                 : (n_acc >= limit_ext)) begin
                reject    = 1'b1;
                rej_cause = CAUSE_LENGTH;
            end else if (n_acc == '0) begin
                res.status     = ST_DONE;
                res.last       = 1'b1;
                n_phase        = PH_IDLE;
                n_arg_left     = '0;
                n_payload_left = '0;
            end else begin
                res.value      = n_acc;
                n_payload_left = n_acc[PAYLOAD_W-1:0];
                n_arg_left     = '0;
                n_phase        = PH_PAYLOAD;
            end
        end

        if (reject) begin
            res             = '0;
            res.status      = ST_REJECT;
            res.error_cause = rej_cause;
            res.last        = 1'b1;
            n_acc           = '0;
            n_phase         = PH_IDLE;
            n_arg_left      = '0;
            n_payload_left  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_IDLE;
            r_kind         <= KIND_UINT;
            r_arg_left     <= '0;
            r_acc          <= '0;
            r_payload_left <= '0;
            r_limit        <= '0;
        end else if (i_accept) begin
            r_phase        <= n_phase;
            r_kind         <= n_kind;
            r_arg_left     <= n_arg_left;
            r_acc          <= n_acc;
            r_payload_left <= n_payload_left;
            r_limit        <= n_limit;
        end
    end

    assign o_result = res;

    `CISD_ASSERT(a_arg_count_live, i_clk, i_rst_n,
        (r_phase == PH_ARG) |-> (r_arg_left != '0), "argument phase with no bytes left")
    `CISD_ASSERT(a_payload_count_live, i_clk, i_rst_n,
        (r_phase == PH_PAYLOAD) |-> (r_payload_left != '0), "payload phase with no bytes left")
    `CISD_ASSERT(a_last_goes_idle, i_clk, i_rst_n,
        (i_accept && o_result.last) |=> (r_phase == PH_IDLE), "item ended but decoder not idle")

endmodule

// ----- design/cisd_out_buf.sv -----
// ----------------------------------------------------------------------------
// CBOR item stream decoder result queue
// Two-entry result register queue between the core and the output port.
// ----------------------------------------------------------------------------
`include "cbor_item_stream_decoder_top_assert.svh"

module cisd_out_buf (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cisd_pkg::t_q_ctrl   i_ctrl,
    input  cisd_pkg::t_out_item i_push_item,
    output logic                o_full,
    output logic                o_valid,
    input  logic                i_stall,
    output cisd_pkg::t_out_item o_item
);
    import cisd_pkg::*;

    t_out_item  r_slot [2];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_count, n_count;
    logic       pop;

    assign o_valid = (r_count != 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign pop     = o_valid && !i_stall;
    assign o_item  = r_slot[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        case ({i_ctrl.push, pop})
            2'b10:   n_count = r_count + 2'd1;
            2'b01:   n_count = r_count - 2'd1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_ctrl.push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.push) begin
            r_slot[r_wr_ptr] <= i_push_item;
        end
    end

    `CISD_ASSERT(a_no_push_when_full, i_clk, i_rst_n, !(i_ctrl.push && (r_count == 2'd2)), "push into full result queue")
    `CISD_ASSERT(a_count_bound, i_clk, i_rst_n, r_count != 2'd3, "result queue count out of range")

endmodule
